/* rtl/core/clnw_pkg.sv */
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types, constants and helpers for the character display nibble writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

    // characters per display line
    localparam int ROW_CHARS    = 16;
    localparam int CURSOR_W     = $clog2(2 * ROW_CHARS + 1);
    localparam int MAX_BYTES    = 5;
    localparam int BYTE_CNT_W   = $clog2(MAX_BYTES + 1);
    localparam int STROBE_IDX_W = $clog2(2 * MAX_BYTES);

    typedef logic [CURSOR_W-1:0] cursor_t;

    typedef enum logic [2:0] {
        FN_INIT  = 3'd0,
        FN_CMD   = 3'd1,
        FN_RAW   = 3'd2,
        FN_CLEAR = 3'd3,
        FN_TEXT  = 3'd4,
        FN_DEC   = 3'd5
    } func_t;

    // pause after a strobe
    localparam logic [1:0] WAIT_200US = 2'd0;
    localparam logic [1:0] WAIT_2MS   = 2'd1;
    localparam logic [1:0] WAIT_4MS   = 2'd2;

    localparam logic [7:0] CMD_HOME4   = 8'h02;
    localparam logic [7:0] CMD_FUNCSET = 8'h28;
    localparam logic [7:0] CMD_DISPON  = 8'h0C;
    localparam logic [7:0] CMD_ENTRY   = 8'h06;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_LINE1   = 8'h80;
    localparam logic [7:0] CMD_LINE2   = 8'hC0;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_SPACE   = 8'h20;

    typedef struct packed {
        logic [7:0] data;
        logic       rs;
        logic [1:0] low_wait;
    } byte_slot_t;

    // bytes queued for one item, sent in slot order
    typedef struct packed {
        byte_slot_t [MAX_BYTES-1:0] slot;
        logic [BYTE_CNT_W-1:0]      nbytes;
        logic                       pw_first;
    } plan_t;

    function automatic byte_slot_t cmd_slot(input logic [7:0] b);
        byte_slot_t s;
        s.data     = b;
        s.rs       = 1'b0;
        s.low_wait = WAIT_2MS;
        return s;
    endfunction

    function automatic byte_slot_t clear_slot();
        byte_slot_t s;
        s.data     = CMD_CLEAR;
        s.rs       = 1'b0;
        s.low_wait = WAIT_4MS;
        return s;
    endfunction

    function automatic byte_slot_t char_slot(input logic [7:0] c);
        byte_slot_t s;
        s.data     = c;
        s.rs       = 1'b1;
        s.low_wait = WAIT_2MS;
        return s;
    endfunction

endpackage

/* rtl/core/clnw_decode.sv */
// ----------------------------------------------------------------------------
// clnw_decode
// Turns one operation into its byte list and tracks the text cursor.
// ----------------------------------------------------------------------------
module clnw_decode (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  clnw_pkg::func_t        func,
    input  logic [7:0]             value,
    input  logic                   string_start,
    input  logic                   take,
    output clnw_pkg::plan_t        plan
);
    import clnw_pkg::*;

    cursor_t    cursor_reg, cursor_next;
    cursor_t    cur;
    logic [13:0] hund_prod;
    logic [1:0]  hundreds;
    logic [7:0]  rem_h;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [7:0]  ones;

    // v/100 as (v*41)>>12, then r/10 as (r*205)>>11; exact over the range
    always_comb begin
        hund_prod = 14'(value) * 14'd41;
        hundreds  = hund_prod[13:12];
        rem_h     = value - 8'(8'(hundreds) * 8'd100);
        tens_prod = 15'(rem_h[6:0]) * 15'd205;
        tens      = tens_prod[14:11];
        ones      = rem_h - 8'(8'(tens) * 8'd10);
    end

    always_comb begin
        plan        = '0;
        cur         = string_start ? '0 : cursor_reg;
        cursor_next = cursor_reg;
        case (func)
            FN_INIT: begin
                plan.slot[0]          = cmd_slot(CMD_HOME4);
                plan.slot[1]          = cmd_slot(CMD_FUNCSET);
                plan.slot[2]          = cmd_slot(CMD_DISPON);
                plan.slot[3]          = cmd_slot(CMD_ENTRY);
                plan.slot[4]          = clear_slot();
                plan.nbytes           = BYTE_CNT_W'(5);
                plan.pw_first         = 1'b1;
            end
            FN_CMD: begin
                plan.slot[0] = cmd_slot(value);
                plan.nbytes  = BYTE_CNT_W'(1);
            end
            FN_RAW: begin
                plan.slot[0] = char_slot(value);
                plan.nbytes  = BYTE_CNT_W'(1);
            end
            FN_CLEAR: begin
                plan.slot[0] = clear_slot();
                plan.slot[1] = cmd_slot(CMD_LINE1);
                plan.nbytes  = BYTE_CNT_W'(2);
            end
            FN_TEXT: begin
                if (cur == CURSOR_W'(ROW_CHARS)) begin
                    plan.slot[0] = cmd_slot(CMD_LINE2);
                    plan.slot[1] = char_slot(value);
                    plan.nbytes  = BYTE_CNT_W'(2);
                    cursor_next  = cur + CURSOR_W'(1);
                end else if (cur >= CURSOR_W'(2 * ROW_CHARS)) begin
                    plan.slot[0] = clear_slot();
                    plan.slot[1] = cmd_slot(CMD_LINE1);
                    plan.slot[2] = cmd_slot(CMD_LINE1);
                    plan.slot[3] = char_slot(value);
                    plan.nbytes  = BYTE_CNT_W'(4);
                    cursor_next  = CURSOR_W'(1);
                end else begin
                    plan.slot[0] = char_slot(value);
                    plan.nbytes  = BYTE_CNT_W'(1);
                    cursor_next  = cur + CURSOR_W'(1);
                end
            end
            FN_DEC: begin
                if (hundreds != 2'd0) begin
                    plan.slot[0] = char_slot(CHR_ZERO + 8'(hundreds));
                    plan.slot[1] = char_slot(CHR_ZERO + 8'(tens));
                    plan.slot[2] = char_slot(CHR_ZERO + ones);
                    plan.slot[3] = char_slot(CHR_SPACE);
                    plan.nbytes  = BYTE_CNT_W'(4);
                end else if (tens != 4'd0) begin
                    plan.slot[0] = char_slot(CHR_ZERO + 8'(tens));
                    plan.slot[1] = char_slot(CHR_ZERO + ones);
                    plan.slot[2] = char_slot(CHR_SPACE);
                    plan.nbytes  = BYTE_CNT_W'(3);
                end else begin
                    plan.slot[0] = char_slot(CHR_ZERO + ones);
                    plan.slot[1] = char_slot(CHR_SPACE);
                    plan.nbytes  = BYTE_CNT_W'(2);
                end
            end
            default: begin
                // unused codes: nothing sent
                plan = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
        end else if (take && func == FN_TEXT) begin
            cursor_reg <= cursor_next;
        end
    end

endmodule

/* rtl/core/clnw_emit.sv */
// ----------------------------------------------------------------------------
// clnw_emit
// Holds the byte list of one item and sends it as nibble strobes through an
// output register, one strobe per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module clnw_emit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  clnw_pkg::plan_t        plan_in,
    input  logic                   in_valid,
    output logic                   plan_free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // nibble[3:0], power_wait_before[4],
                                              // wait_after[6:5], zero[7]
    output logic                   m_tuser,   // reg_select
    output logic                   m_tlast
);
    import clnw_pkg::*;

    plan_t                   plan_reg;
    logic                    busy_reg;
    logic [STROBE_IDX_W-1:0] idx_reg;
    logic                    m_valid_reg;
    logic [3:0]              nib_reg;
    logic                    pw_reg;
    logic [1:0]              wait_reg;
    logic                    rs_reg;
    logic                    last_reg;

    logic                    out_load;
    logic                    step;
    logic                    is_last;
    byte_slot_t              sel;
    logic                    load_plan;

    always_comb begin
        sel = plan_reg.slot[0];
        for (int i = 0; i < MAX_BYTES; i++) begin
            if (idx_reg[STROBE_IDX_W-1:1] == (STROBE_IDX_W-1)'(i)) begin
                sel = plan_reg.slot[i];
            end
        end
    end

    assign out_load  = !m_valid_reg || m_tready;
    assign step      = busy_reg && out_load;
    assign is_last   = idx_reg == STROBE_IDX_W'({plan_reg.nbytes, 1'b0} - 1'b1);
    assign plan_free = !busy_reg || (step && is_last);
    assign load_plan = in_valid && plan_free && (plan_in.nbytes != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load_plan) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (step) begin
            idx_reg <= idx_reg + 1'b1;
            if (is_last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_plan) begin
            plan_reg <= plan_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= step;
        end
    end

    // high nibble on even index, low nibble on odd
    always_ff @(posedge aclk) begin
        if (step) begin
            nib_reg  <= idx_reg[0] ? sel.data[3:0] : sel.data[7:4];
            wait_reg <= idx_reg[0] ? sel.low_wait : WAIT_200US;
            pw_reg   <= plan_reg.pw_first && (idx_reg == '0);
            rs_reg   <= sel.rs;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, wait_reg, pw_reg, nib_reg};
    assign m_tuser  = rs_reg;
    assign m_tlast  = last_reg;

endmodule

/* rtl/core/char_lcd_nibble_writer.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// Character display writer: each operation becomes 4-bit strobes for the
// display bus, high nibble first, with register select and wait codes.
//
//   channel | ports      | tdata                         | tuser
//   --------+------------+-------------------------------+-------------------------
//   in      | s_t*       | value[7:0]                    | func[2:0], string_start[3]
//   out     | m_t*       | nibble, pwait, wait_after     | reg_select; tlast = last
//
// An item yields 2 to 10 strobes, one per cycle while the output is not
// stalled, two per byte; an item of unused code is taken and yields none.
// The next item is taken in the cycle the previous item's final strobe
// enters the output register. Output stalls hold the register and the
// sequencer. Reset clears the cursor and all valid state.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // value[7:0]
    input  logic [3:0] s_tuser,    // func[2:0], string_start[3]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // nibble[3:0], power_wait_before[4],
                                   // wait_after[6:5], zero[7]
    output logic       m_tuser,    // reg_select
    output logic       m_tlast
);
    import clnw_pkg::*;

    plan_t plan;
    logic  plan_free;
    logic  s_accept;

    assign s_tready = plan_free;
    assign s_accept = s_tvalid && plan_free;

    clnw_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .func         (func_t'(s_tuser[2:0])),
        .value        (s_tdata),
        .string_start (s_tuser[3]),
        .take         (s_accept),
        .plan         (plan)
    );

    clnw_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .plan_in   (plan),
        .in_valid  (s_tvalid),
        .plan_free (plan_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // power-up wait only on the high nibble of a command
    a_pwait_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> !m_tuser && m_tdata[6:5] == WAIT_200US)
        else $error("power wait on wrong strobe");

    a_wait_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:5] != 2'd3)
        else $error("bad wait code");

    // strobes within one item follow without gaps
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside an item");

    // no new item taken while a non-last strobe is held by an output stall
    a_hold_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && !m_tlast |-> !s_tready)
        else $error("item taken mid-sequence");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the character display nibble writer. Display
// operations are sent on the input channel and a scoreboard works out the
// strobes that each one must yield. It keeps its own cursor copy. Each
// strobe taken from the output channel is checked field by field against
// the oldest pending strobe. Both channels idle at random. One long
// output hold-off fills the block, and drain pauses let it empty.
// ----------------------------------------------------------------------------
import clnw_pkg::*;

typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic       pw;
    logic [1:0] wait_after;
    logic       last;
} strobe_t;

class lcd_scoreboard;
    strobe_t pending[$];
    cursor_t cursor;
    int      errors;

    function new();
        cursor = '0;
        errors = 0;
    endfunction

    // one byte goes out as high nibble, then low nibble
    function void add_byte(logic [7:0] b, logic rs, logic pw, logic [1:0] low_wait);
        strobe_t s;
        s = '{nibble: b[7:4], rs: rs, pw: pw, wait_after: WAIT_200US, last: 1'b0};
        pending.push_back(s);
        s = '{nibble: b[3:0], rs: rs, pw: 1'b0, wait_after: low_wait, last: 1'b0};
        pending.push_back(s);
    endfunction

    function void add_clear();
        add_byte(CMD_CLEAR, 1'b0, 1'b0, WAIT_4MS);
        add_byte(CMD_LINE1, 1'b0, 1'b0, WAIT_2MS);
    endfunction

    function void note_item(logic [2:0] func, logic [7:0] value, logic start);
        int first;
        first = pending.size();
        case (func)
            FN_INIT: begin
                add_byte(CMD_HOME4, 1'b0, 1'b1, WAIT_2MS);
                add_byte(CMD_FUNCSET, 1'b0, 1'b0, WAIT_2MS);
                add_byte(CMD_DISPON, 1'b0, 1'b0, WAIT_2MS);
                add_byte(CMD_ENTRY, 1'b0, 1'b0, WAIT_2MS);
                add_byte(CMD_CLEAR, 1'b0, 1'b0, WAIT_4MS);
            end
            FN_CMD:   add_byte(value, 1'b0, 1'b0, WAIT_2MS);
            FN_RAW:   add_byte(value, 1'b1, 1'b0, WAIT_2MS);
            FN_CLEAR: add_clear();
            FN_TEXT: begin
                if (start)
                    cursor = '0;
                if (cursor == cursor_t'(ROW_CHARS)) begin
                    add_byte(CMD_LINE2, 1'b0, 1'b0, WAIT_2MS);
                end else if (cursor >= cursor_t'(2 * ROW_CHARS)) begin
                    // full display: clear, home, then home again
                    add_clear();
                    add_byte(CMD_LINE1, 1'b0, 1'b0, WAIT_2MS);
                    cursor = '0;
                end
                add_byte(value, 1'b1, 1'b0, WAIT_2MS);
                cursor = cursor + 1'b1;
            end
            FN_DEC: begin
                if (value >= 8'd100) begin
                    add_byte(CHR_ZERO + value / 8'd100, 1'b1, 1'b0, WAIT_2MS);
                    add_byte(CHR_ZERO + (value / 8'd10) % 8'd10, 1'b1, 1'b0, WAIT_2MS);
                end else if (value >= 8'd10) begin
                    add_byte(CHR_ZERO + value / 8'd10, 1'b1, 1'b0, WAIT_2MS);
                end
                add_byte(CHR_ZERO + value % 8'd10, 1'b1, 1'b0, WAIT_2MS);
                add_byte(CHR_SPACE, 1'b1, 1'b0, WAIT_2MS);
            end
            default: ;  // unused codes yield nothing
        endcase
        if (pending.size() > first)
            pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void flag(string field, int exp_val, int got_val);
        errors++;
        $display("%0t: strobe %s mismatch, expected %0d, actual %0d",
                 $time, field, exp_val, got_val);
    endfunction

    function void check_strobe(logic [7:0] tdata, logic tuser, logic tlast);
        strobe_t exp_s;
        if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected strobe, expected none, actual tdata %h tuser %b tlast %b",
                     $time, tdata, tuser, tlast);
            return;
        end
        exp_s = pending.pop_front();
        if (tdata[3:0] !== exp_s.nibble)
            flag("nibble", int'(exp_s.nibble), int'(tdata[3:0]));
        if (tdata[4] !== exp_s.pw)
            flag("power_wait_before", int'(exp_s.pw), int'(tdata[4]));
        if (tdata[6:5] !== exp_s.wait_after)
            flag("wait_after", int'(exp_s.wait_after), int'(tdata[6:5]));
        if (tdata[7] !== 1'b0)
            flag("pad bit", 0, int'(tdata[7]));
        if (tuser !== exp_s.rs)
            flag("reg_select", int'(exp_s.rs), int'(tuser));
        if (tlast !== exp_s.last)
            flag("last", int'(exp_s.last), int'(tlast));
    endfunction
endclass

module testbench;

    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RAND_ITEMS  = 200;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic [3:0] s_tuser  = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    bit hold_off_req = 1'b0;
    bit quiet        = 1'b0;
    int idle_cycles  = 0;

    lcd_scoreboard board = new();

    char_lcd_nibble_writer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // offer one item, note it when taken, then maybe idle
    task automatic offer_item(logic [2:0] func, logic [7:0] value, logic start);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= {start, func};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_item(func, value, start);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge aclk);
    endtask

    // output side: random stalls, one long hold-off on request
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (quiet || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_strobe(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int  useful;
        int  run_len;
        bit  hold_done;
        logic [2:0] fn;

        useful    = 0;
        hold_done = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every operation, field extremes, decimal corners
        offer_item(FN_INIT, 8'h00, 1'b0);
        offer_item(FN_CMD, 8'h00, 1'b0);
        offer_item(FN_CMD, 8'hFF, 1'b1);   // start flag ignored off text
        offer_item(FN_RAW, 8'h00, 1'b0);
        offer_item(FN_RAW, 8'hFF, 1'b0);
        offer_item(FN_CLEAR, 8'hA5, 1'b0);
        offer_item(FN_DEC, 8'd0, 1'b0);
        offer_item(FN_DEC, 8'd9, 1'b0);
        offer_item(FN_DEC, 8'd10, 1'b0);
        offer_item(FN_DEC, 8'd99, 1'b0);
        offer_item(FN_DEC, 8'd100, 1'b0);
        offer_item(FN_DEC, 8'd105, 1'b0);  // inner zero kept
        offer_item(FN_DEC, 8'd200, 1'b0);
        offer_item(FN_DEC, 8'd255, 1'b1);
        offer_item(3'd6, 8'h5A, 1'b1);     // unused codes
        offer_item(3'd7, 8'hFF, 1'b0);
        offer_item(FN_TEXT, 8'h41, 1'b1);
        offer_item(FN_TEXT, 8'hFF, 1'b0);
        offer_item(FN_TEXT, 8'h00, 1'b0);
        offer_item(FN_TEXT, 8'h5A, 1'b1);
        drain();

        // random: mostly text runs long enough to hit line two and wrap
        while (useful < RAND_ITEMS) begin
            if (useful >= 60 && !hold_done) begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (useful >= RAND_ITEMS - 40)
                quiet = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    run_len = $urandom_range(0, 1) ? $urandom_range(1, 8)
                                                   : $urandom_range(17, 40);
                    for (int i = 0; i < run_len; i++)
                        offer_item(FN_TEXT, 8'($urandom_range(0, 255)),
                                   (i == 0) ? ($urandom_range(0, 1) == 1) : 1'b0);
                    useful += run_len;
                end
                6, 7, 8: begin
                    fn = 3'($urandom_range(0, 5));
                    offer_item(fn, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    useful++;
                end
                default: begin
                    fn = 3'($urandom_range(6, 7));
                    offer_item(fn, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            endcase
        end

        drain();
        repeat (40) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/clnw_pkg.sv
rtl/core/clnw_decode.sv
rtl/core/clnw_emit.sv
rtl/core/char_lcd_nibble_writer.sv
tb/testbench.sv
